/* sv/idwf_pkg.sv */
// ----------------------------------------------------------------------------
// idwf_pkg
// Shared types and constants of the display write framer: symbol codes,
// request kinds, frame bytes and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package idwf_pkg;

    // bus symbol codes
    typedef logic [2:0] symbol_t;
    localparam symbol_t SYM_START = 3'd0;
    localparam symbol_t SYM_BIT   = 3'd1;
    localparam symbol_t SYM_ACK   = 3'd2;
    localparam symbol_t SYM_STOP  = 3'd3;
    localparam symbol_t SYM_PULSE = 3'd4;

    // request kinds
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_COMMAND  = 2'd0;
    localparam kind_t KIND_DATA     = 2'd1;
    localparam kind_t KIND_RECOVERY = 2'd2;
    localparam kind_t KIND_UNUSED   = 2'd3;

    // frame bytes
    localparam logic [7:0] CTRL_COMMAND = 8'h00;
    localparam logic [7:0] CTRL_DATA    = 8'h40;
    localparam logic [7:0] ADDR_RESET   = 8'h78;

    // recovery pulse count, capped so a run never exceeds the frame length
    localparam int RECOVERY_PULSES = 15;
    localparam int MAX_RESULTS     = 29;
    localparam int PULSE_COUNT     = (RECOVERY_PULSES > MAX_RESULTS - 1) ?
                                     MAX_RESULTS - 1 : RECOVERY_PULSES;
    localparam int PULSE_W         = $clog2(MAX_RESULTS);
    localparam logic [PULSE_W-1:0] PULSE_INIT = PULSE_W'(PULSE_COUNT);

    // configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_DEVICE_ADDRESS = 1'b0;

    // frame byte positions
    typedef logic [1:0] byte_idx_t;
    localparam byte_idx_t BYTE_ADDR    = 2'd0;
    localparam byte_idx_t BYTE_CTRL    = 2'd1;
    localparam byte_idx_t BYTE_PAYLOAD = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic    load;       // capture a new request
        logic    emit;       // put a symbol into the output register
        symbol_t sym;
        logic    use_bit;    // sda from the shift register msb
        logic    sda_fix;    // sda otherwise
        logic    last;
        logic    shift;      // advance to the next bit of the byte
        logic    next_byte;  // load the next frame byte
        logic    pulse_dec;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;      // output register can take a symbol
        logic in_frame;      // request on the input is a frame
        logic in_recovery;   // request on the input is a recovery
        logic bit_last;
        logic byte_last;
        logic pulse_last;
    } status_t;

endpackage

/* sv/idwf_ctrl.sv */
// ----------------------------------------------------------------------------
// idwf_ctrl
// Sequencer of the framer: walks start, address/control/payload bytes with
// their ack clocks and the stop, or the recovery pulses and the stop.
// ----------------------------------------------------------------------------
module idwf_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  idwf_pkg::status_t status,
    output idwf_pkg::cmd_t    cmd
);
    import idwf_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_BIT   = 3'd2;
    localparam logic [2:0] ST_ACK   = 3'd3;
    localparam logic [2:0] ST_PULSE = 3'd4;
    localparam logic [2:0] ST_STOP  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // busy for the whole run
    assign in_stall = (state_reg != ST_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (status.in_frame)
                        state_next = ST_START;
                    else if (status.in_recovery)
                        state_next = ST_PULSE;
                end
            end
            ST_START:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sym    = SYM_START;
                    state_next = ST_BIT;
                end
            end
            ST_BIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.sym     = SYM_BIT;
                    cmd.use_bit = 1'b1;
                    cmd.shift   = 1'b1;
                    if (status.bit_last)
                        state_next = ST_ACK;
                end
            end
            ST_ACK:
            begin
                if (status.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.sym     = SYM_ACK;
                    cmd.sda_fix = 1'b1;
                    if (status.byte_last)
                        state_next = ST_STOP;
                    else
                    begin
                        cmd.next_byte = 1'b1;
                        state_next    = ST_BIT;
                    end
                end
            end
            ST_PULSE:
            begin
                if (status.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.sym       = SYM_PULSE;
                    cmd.sda_fix   = 1'b1;
                    cmd.pulse_dec = 1'b1;
                    if (status.pulse_last)
                        state_next = ST_STOP;
                end
            end
            ST_STOP:
            begin
                if (status.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.sym     = SYM_STOP;
                    cmd.sda_fix = 1'b1;
                    cmd.last    = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

/* sv/idwf_dp.sv */
// ----------------------------------------------------------------------------
// idwf_dp
// Datapath of the framer: device address register, byte shift register,
// bit/byte/pulse counters and the output symbol register.
// ----------------------------------------------------------------------------
module idwf_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_we,
    input  logic [idwf_pkg::APB_AW-1:0]   cfg_addr,
    input  logic [idwf_pkg::APB_DW-1:0]   cfg_wdata,
    output logic [idwf_pkg::APB_DW-1:0]   cfg_rdata,
    // request
    input  idwf_pkg::kind_t               kind,
    input  logic [7:0]                    payload,
    // symbols
    output logic                          out_valid,
    input  logic                          out_stall,
    output idwf_pkg::symbol_t             symbol,
    output logic                          sda_level,
    output logic                          last,
    // control
    input  idwf_pkg::cmd_t                cmd,
    output idwf_pkg::status_t             status
);
    import idwf_pkg::*;

    logic [7:0]         dev_addr_reg;
    logic [7:0]         shift_reg;
    logic [7:0]         shift_next;
    logic [2:0]         bit_cnt_reg;
    logic [2:0]         bit_cnt_next;
    byte_idx_t          byte_idx_reg;
    byte_idx_t          byte_idx_next;
    logic [PULSE_W-1:0] pulse_cnt_reg;
    logic [PULSE_W-1:0] pulse_cnt_next;
    logic               data_kind_reg;
    logic [7:0]         payload_reg;
    logic               out_valid_reg;
    symbol_t            sym_reg;
    logic               sda_reg;
    logic               last_reg;
    logic               out_free;

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dev_addr_reg <= ADDR_RESET;
        else if (cfg_we && cfg_addr[2] == REG_DEVICE_ADDRESS)
            dev_addr_reg <= cfg_wdata[7:0];
    end

    assign cfg_rdata = (cfg_addr[2] == REG_DEVICE_ADDRESS) ?
                       {{(APB_DW-8){1'b0}}, dev_addr_reg} : '0;

    // status back to the controller
    assign out_free = !out_valid_reg || !out_stall;
    always_comb
    begin
        status.out_free    = out_free;
        status.in_frame    = (kind == KIND_COMMAND) || (kind == KIND_DATA);
        status.in_recovery = (kind == KIND_RECOVERY);
        status.bit_last    = (bit_cnt_reg == 3'd0);
        status.byte_last   = (byte_idx_reg == BYTE_PAYLOAD);
        status.pulse_last  = (pulse_cnt_reg == PULSE_W'(1));
    end

    // byte sequencing
    always_comb
    begin
        shift_next     = shift_reg;
        bit_cnt_next   = bit_cnt_reg;
        byte_idx_next  = byte_idx_reg;
        pulse_cnt_next = pulse_cnt_reg;
        priority if (cmd.load)
        begin
            shift_next     = dev_addr_reg;
            bit_cnt_next   = 3'd7;
            byte_idx_next  = BYTE_ADDR;
            pulse_cnt_next = PULSE_INIT;
        end
        else if (cmd.next_byte)
        begin
            shift_next    = (byte_idx_reg == BYTE_ADDR) ?
                            (data_kind_reg ? CTRL_DATA : CTRL_COMMAND) : payload_reg;
            bit_cnt_next  = 3'd7;
            byte_idx_next = byte_idx_reg + 2'd1;
        end
        else if (cmd.shift)
        begin
            shift_next   = {shift_reg[6:0], 1'b0};
            bit_cnt_next = bit_cnt_reg - 3'd1;
        end
        else if (cmd.pulse_dec)
        begin
            pulse_cnt_next = pulse_cnt_reg - PULSE_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg     <= shift_next;
        bit_cnt_reg   <= bit_cnt_next;
        byte_idx_reg  <= byte_idx_next;
        pulse_cnt_reg <= pulse_cnt_next;
        if (cmd.load)
        begin
            data_kind_reg <= (kind == KIND_DATA);
            payload_reg   <= payload;
        end
    end

    // output symbol register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= cmd.emit;
    end

    always_ff @(posedge clk)
    begin
        if (out_free && cmd.emit)
        begin
            sym_reg  <= cmd.sym;
            sda_reg  <= cmd.use_bit ? shift_reg[7] : cmd.sda_fix;
            last_reg <= cmd.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign symbol    = sym_reg;
    assign sda_level = sda_reg;
    assign last      = last_reg;

endmodule

/* sv/i2c_display_write_framer.sv */
// ----------------------------------------------------------------------------
// i2c_display_write_framer
// Write-only I2C master framer: turns command, data and recovery requests
// into runs of bus symbols, one symbol per result.
//
//   channel   direction  handshake            payload
//   request   in         in_valid / in_stall  kind, payload
//   symbol    out        out_valid/out_stall  symbol, sda_level, last
//   config    in         APB write/read       device_address at 0x0
//
// A frame is a capture and then 29 symbols, a recovery run a capture, then
// PULSE_COUNT pulses and the stop; the symbol sequencer emits one symbol per
// cycle while the output does not stall. in_stall stays high for the run.
// An unused kind is taken and dropped without starting a run.
// Reset clears the sequencer and output valid and sets device_address to 0x78.
// ----------------------------------------------------------------------------
module i2c_display_write_framer (
    input  logic                          clk,
    input  logic                          rst_n,
    // request channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  idwf_pkg::kind_t               kind,
    input  logic [7:0]                    payload,
    // symbol channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output idwf_pkg::symbol_t             symbol,
    output logic                          sda_level,
    output logic                          last,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [idwf_pkg::APB_AW-1:0]   paddr,
    input  logic [idwf_pkg::APB_DW-1:0]   pwdata,
    output logic [idwf_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import idwf_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    cfg_we;

    // register write strobe
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    idwf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    idwf_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (paddr),
        .cfg_wdata (pwdata),
        .cfg_rdata (prdata),
        .kind      (kind),
        .payload   (payload),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .symbol    (symbol),
        .sda_level (sda_level),
        .last      (last),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

/* sv/idwf_checker.sv */
// ----------------------------------------------------------------------------
// idwf_checker
// Port-level checks of the framer: symbol encoding rules, busy after a
// request and a held symbol under stall.
// ----------------------------------------------------------------------------
module idwf_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input idwf_pkg::kind_t   kind,
    input logic              out_valid,
    input logic              out_stall,
    input idwf_pkg::symbol_t symbol,
    input logic              sda_level,
    input logic              last
);
    import idwf_pkg::*;

    // a frame or recovery request keeps the block busy next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && kind != KIND_UNUSED) |=> in_stall)
        else $error("request not followed by busy");

    // only a stop ends a run, with sda released
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last) |-> (symbol == SYM_STOP && sda_level))
        else $error("last on a symbol other than stop");

    // start drives sda low and never ends a run
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && symbol == SYM_START) |-> (!sda_level && !last))
        else $error("bad start symbol");

    // ack clocks and recovery pulses leave sda released
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (symbol == SYM_ACK || symbol == SYM_PULSE)) |-> sda_level)
        else $error("sda driven on ack or pulse");

    // stalled symbol holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(symbol) && $stable(sda_level) && $stable(last)))
        else $error("stalled symbol changed");

endmodule

bind i2c_display_write_framer idwf_checker u_idwf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .symbol    (symbol),
    .sda_level (sda_level),
    .last      (last)
);
